// ===== rtl/dlms_ph_pkg.sv =====
package dlms_ph_pkg;

  localparam int DefMaxTitleBytes = 8;

  localparam int PhaseW  = 4;
  localparam int CountW  = 17;
  localparam int StatusW = 3;

  // parser phases
  localparam logic [PhaseW-1:0] PH_VER      = 4'd0;
  localparam logic [PhaseW-1:0] PH_SRC      = 4'd1;
  localparam logic [PhaseW-1:0] PH_DST      = 4'd2;
  localparam logic [PhaseW-1:0] PH_WLEN     = 4'd3;
  localparam logic [PhaseW-1:0] PH_TAG      = 4'd4;
  localparam logic [PhaseW-1:0] PH_TLEN     = 4'd5;
  localparam logic [PhaseW-1:0] PH_TLEN_EXT = 4'd6;
  localparam logic [PhaseW-1:0] PH_TITLE    = 4'd7;
  localparam logic [PhaseW-1:0] PH_CLEN     = 4'd8;
  localparam logic [PhaseW-1:0] PH_CLEN_EXT = 4'd9;
  localparam logic [PhaseW-1:0] PH_SEC      = 4'd10;
  localparam logic [PhaseW-1:0] PH_FC       = 4'd11;
  localparam logic [PhaseW-1:0] PH_PAYLOAD  = 4'd12;

  // status codes
  localparam logic [StatusW-1:0] ST_OK    = 3'd0;
  localparam logic [StatusW-1:0] ST_WLEN  = 3'd1;
  localparam logic [StatusW-1:0] ST_TAG   = 3'd2;
  localparam logic [StatusW-1:0] ST_BER   = 3'd3;
  localparam logic [StatusW-1:0] ST_CLEN  = 3'd4;
  localparam logic [StatusW-1:0] ST_TRUNC = 3'd5;
  localparam logic [StatusW-1:0] ST_TITLE = 3'd6;

  // security modes
  localparam logic [1:0] SEC_NONE     = 2'd0;
  localparam logic [1:0] SEC_AUTH     = 2'd1;
  localparam logic [1:0] SEC_ENC      = 2'd2;
  localparam logic [1:0] SEC_AUTH_ENC = 2'd3;

  // byte codes
  localparam logic [7:0] TAG_GLO_CIPHER = 8'hDB;
  localparam logic [7:0] BER_SHORT_MAX  = 8'h80;
  localparam logic [7:0] BER_LONG1      = 8'h81;
  localparam logic [7:0] BER_LONG2      = 8'h82;
  localparam logic [7:0] BER_LONG4      = 8'h84;
  localparam logic [7:0] SC_AUTH        = 8'h10;
  localparam logic [7:0] SC_ENC         = 8'h20;
  localparam logic [7:0] SC_AUTH_ENC    = 8'h30;

  localparam logic [CountW-1:0] COUNT_MAX     = 17'h1FFFF;
  localparam logic [CountW-1:0] WRAP_HDR_SIZE = 17'd8;

endpackage

// ===== rtl/dlms_push_header_parser.sv =====
// DLMS wrapper push header parser. Takes one packet byte per cycle with a last
// flag and returns one result per packet, carrying the wrapper header fields,
// the general-glo-ciphering system title, security mode, frame counter and a
// status code. An accepted byte sits in the input register, from which the field
// state machine updates and, for a last byte, loads the result register, so a
// result is registered after its last byte is accepted; a new byte is accepted
// in every cycle that is not stalled. The only stall comes from a
// held result: a last byte waits in the input register while the previous
// result is stalled at the output. Payload bytes after the header are counted
// only. The parser returns to its initial state after every last byte.
module dlms_push_header_parser #(
  parameter int MAX_TITLE_BYTES = dlms_ph_pkg::DefMaxTitleBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_version,
  output logic [15:0] out_source_addr,
  output logic [15:0] out_dest_addr,
  output logic [1:0]  out_security_mode,
  output logic [31:0] out_frame_counter,
  output logic [63:0] out_system_title,
  output logic [3:0]  out_title_length
);

  localparam logic [3:0]  MaxTitle4  = 4'(MAX_TITLE_BYTES);
  localparam logic [31:0] MaxTitle32 = 32'(MAX_TITLE_BYTES);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // parser state
  logic [3:0]  phase_r, phase_nxt;
  logic [16:0] byte_cnt_r, byte_cnt_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [15:0] wlen_r, wlen_nxt;
  logic [31:0] ber_len_r, ber_len_nxt;
  logic [2:0]  ber_left_r, ber_left_nxt;
  logic [63:0] title_r, title_nxt;
  logic [3:0]  title_cnt_r, title_cnt_nxt;
  logic [15:0] ver_r, ver_nxt;
  logic [15:0] src_r, src_nxt;
  logic [15:0] dst_r, dst_nxt;
  logic [1:0]  sec_r, sec_nxt;
  logic [31:0] fc_r, fc_nxt;
  logic [2:0]  err_r, err_nxt;

  // result register
  logic        out_valid_r;
  logic [2:0]  status_r, status_nxt;
  logic [15:0] o_ver_r, o_src_r, o_dst_r;
  logic [1:0]  o_sec_r;
  logic [31:0] o_fc_r;
  logic [63:0] o_title_r;
  logic [3:0]  o_tlen_r;

  logic       proc_go;
  logic       in_accept;
  logic       stopped;
  logic       hdr16;
  logic       do_start;
  logic [2:0] left_dec;
  logic [7:0] b;

  assign b         = s1_byte_r;
  assign proc_go   = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !proc_go;
  assign in_accept = in_valid && !in_stall;
  assign stopped   = (err_r == dlms_ph_pkg::ST_TAG) || (err_r == dlms_ph_pkg::ST_BER);

  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    wlen_nxt      = wlen_r;
    ber_len_nxt   = ber_len_r;
    ber_left_nxt  = ber_left_r;
    title_nxt     = title_r;
    title_cnt_nxt = title_cnt_r;
    ver_nxt       = ver_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    sec_nxt       = sec_r;
    fc_nxt        = fc_r;
    err_nxt       = err_r;
    hdr16         = 1'b0;
    do_start      = 1'b0;
    left_dec      = 3'd0;
    byte_cnt_nxt  = (byte_cnt_r != dlms_ph_pkg::COUNT_MAX) ? byte_cnt_r + 17'd1 : byte_cnt_r;

    if (!stopped) begin
      // everything from the security byte on counts against the cipher length
      if (phase_r >= dlms_ph_pkg::PH_SEC) begin
        if (ber_len_r == 32'd0) begin
          if (err_nxt == dlms_ph_pkg::ST_OK) err_nxt = dlms_ph_pkg::ST_CLEN;
        end else begin
          ber_len_nxt = ber_len_r - 32'd1;
        end
      end
      case (phase_r)
        dlms_ph_pkg::PH_VER: begin
          ver_nxt = {ver_r[7:0], b};
          hdr16   = 1'b1;
        end
        dlms_ph_pkg::PH_SRC: begin
          src_nxt = {src_r[7:0], b};
          hdr16   = 1'b1;
        end
        dlms_ph_pkg::PH_DST: begin
          dst_nxt = {dst_r[7:0], b};
          hdr16   = 1'b1;
        end
        dlms_ph_pkg::PH_WLEN: begin
          wlen_nxt = {wlen_r[7:0], b};
          hdr16    = 1'b1;
        end
        dlms_ph_pkg::PH_TAG: begin
          if (b == dlms_ph_pkg::TAG_GLO_CIPHER) begin
            phase_nxt = dlms_ph_pkg::PH_TLEN;
          end else if (err_nxt == dlms_ph_pkg::ST_OK) begin
            err_nxt = dlms_ph_pkg::ST_TAG;
          end
        end
        dlms_ph_pkg::PH_TLEN, dlms_ph_pkg::PH_CLEN: begin
          if (b <= dlms_ph_pkg::BER_SHORT_MAX) begin
            ber_len_nxt = {24'd0, b};
            if (phase_r == dlms_ph_pkg::PH_TLEN) do_start = 1'b1;
            else phase_nxt = dlms_ph_pkg::PH_SEC;
          end else if (b == dlms_ph_pkg::BER_LONG1 || b == dlms_ph_pkg::BER_LONG2 ||
                       b == dlms_ph_pkg::BER_LONG4) begin
            ber_len_nxt  = 32'd0;
            ber_left_nxt = (b == dlms_ph_pkg::BER_LONG1) ? 3'd1 :
                           (b == dlms_ph_pkg::BER_LONG2) ? 3'd2 : 3'd4;
            phase_nxt    = phase_r + 4'd1;
          end else if (err_nxt == dlms_ph_pkg::ST_OK) begin
            err_nxt = dlms_ph_pkg::ST_BER;
          end
        end
        dlms_ph_pkg::PH_TLEN_EXT, dlms_ph_pkg::PH_CLEN_EXT: begin
          ber_len_nxt  = {ber_len_r[23:0], b};
          left_dec     = (ber_left_r != 3'd0) ? ber_left_r - 3'd1 : 3'd0;
          ber_left_nxt = left_dec;
          if (left_dec == 3'd0) begin
            if (phase_r == dlms_ph_pkg::PH_TLEN_EXT) do_start = 1'b1;
            else phase_nxt = dlms_ph_pkg::PH_SEC;
          end
        end
        dlms_ph_pkg::PH_TITLE: begin
          if (title_cnt_r < MaxTitle4) begin
            title_nxt     = {title_r[55:0], b};
            title_cnt_nxt = title_cnt_r + 4'd1;
          end
          if (ber_len_r != 32'd0) ber_len_nxt = ber_len_r - 32'd1;
          if (ber_len_nxt == 32'd0) phase_nxt = dlms_ph_pkg::PH_CLEN;
        end
        dlms_ph_pkg::PH_SEC: begin
          if (b == dlms_ph_pkg::SC_AUTH) sec_nxt = dlms_ph_pkg::SEC_AUTH;
          else if (b == dlms_ph_pkg::SC_ENC) sec_nxt = dlms_ph_pkg::SEC_ENC;
          else if (b == dlms_ph_pkg::SC_AUTH_ENC) sec_nxt = dlms_ph_pkg::SEC_AUTH_ENC;
          else sec_nxt = dlms_ph_pkg::SEC_NONE;
          phase_nxt = dlms_ph_pkg::PH_FC;
        end
        dlms_ph_pkg::PH_FC: begin
          fc_nxt  = {fc_r[23:0], b};
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) phase_nxt = dlms_ph_pkg::PH_PAYLOAD;
        end
        default: begin
        end
      endcase

      if (hdr16) begin
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd1) begin
          idx_nxt   = 2'd0;
          phase_nxt = phase_r + 4'd1;
        end
      end

      if (do_start) begin
        if (ber_len_nxt > MaxTitle32 && err_nxt == dlms_ph_pkg::ST_OK) begin
          err_nxt = dlms_ph_pkg::ST_TITLE;
        end
        phase_nxt = (ber_len_nxt == 32'd0) ? dlms_ph_pkg::PH_CLEN : dlms_ph_pkg::PH_TITLE;
      end
    end
  end

  always_comb begin
    if (phase_nxt <= dlms_ph_pkg::PH_WLEN) begin
      status_nxt = dlms_ph_pkg::ST_TRUNC;
    end else if (byte_cnt_nxt != {1'b0, wlen_nxt} + dlms_ph_pkg::WRAP_HDR_SIZE) begin
      status_nxt = dlms_ph_pkg::ST_WLEN;
    end else if (err_nxt != dlms_ph_pkg::ST_OK) begin
      status_nxt = err_nxt;
    end else if (phase_nxt >= dlms_ph_pkg::PH_SEC && ber_len_nxt != 32'd0) begin
      status_nxt = dlms_ph_pkg::ST_CLEN;
    end else if (phase_nxt < dlms_ph_pkg::PH_PAYLOAD) begin
      status_nxt = dlms_ph_pkg::ST_TRUNC;
    end else begin
      status_nxt = dlms_ph_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (proc_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (proc_go && s1_last_r)) begin
      phase_r     <= dlms_ph_pkg::PH_VER;
      byte_cnt_r  <= '0;
      idx_r       <= '0;
      wlen_r      <= '0;
      ber_len_r   <= '0;
      ber_left_r  <= '0;
      title_r     <= '0;
      title_cnt_r <= '0;
      ver_r       <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      sec_r       <= '0;
      fc_r        <= '0;
      err_r       <= dlms_ph_pkg::ST_OK;
    end else if (proc_go) begin
      phase_r     <= phase_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      idx_r       <= idx_nxt;
      wlen_r      <= wlen_nxt;
      ber_len_r   <= ber_len_nxt;
      ber_left_r  <= ber_left_nxt;
      title_r     <= title_nxt;
      title_cnt_r <= title_cnt_nxt;
      ver_r       <= ver_nxt;
      src_r       <= src_nxt;
      dst_r       <= dst_nxt;
      sec_r       <= sec_nxt;
      fc_r        <= fc_nxt;
      err_r       <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // fields whose bytes never all arrived read as zero
  always_ff @(posedge clk) begin
    if (proc_go && s1_last_r) begin
      status_r  <= status_nxt;
      o_ver_r   <= (phase_nxt > dlms_ph_pkg::PH_VER) ? ver_nxt : 16'd0;
      o_src_r   <= (phase_nxt > dlms_ph_pkg::PH_SRC) ? src_nxt : 16'd0;
      o_dst_r   <= (phase_nxt > dlms_ph_pkg::PH_DST) ? dst_nxt : 16'd0;
      o_sec_r   <= (phase_nxt > dlms_ph_pkg::PH_SEC) ? sec_nxt : dlms_ph_pkg::SEC_NONE;
      o_fc_r    <= (phase_nxt >= dlms_ph_pkg::PH_PAYLOAD) ? fc_nxt : 32'd0;
      o_title_r <= (phase_nxt > dlms_ph_pkg::PH_TITLE) ? title_nxt : 64'd0;
      o_tlen_r  <= (phase_nxt > dlms_ph_pkg::PH_TITLE) ? title_cnt_nxt : 4'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_version       = o_ver_r;
  assign out_source_addr   = o_src_r;
  assign out_dest_addr     = o_dst_r;
  assign out_security_mode = o_sec_r;
  assign out_frame_counter = o_fc_r;
  assign out_system_title  = o_title_r;
  assign out_title_length  = o_tlen_r;

endmodule

// ===== tb/tb_dlms_push_header_parser.sv =====
`timescale 1ns / 100ps

module tb_dlms_push_header_parser;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int MaxTitle   = dlms_ph_pkg::DefMaxTitleBytes;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] version;
    logic [15:0] source_addr;
    logic [15:0] dest_addr;
    logic [1:0]  security_mode;
    logic [31:0] frame_counter;
    logic [63:0] system_title;
    logic [3:0]  title_length;
  } push_result_t;

  class push_header_scoreboard;
    push_result_t expected_headers[$];
    int errors;
    logic [dlms_ph_pkg::PhaseW-1:0] phase;
    int unsigned byte_count;
    logic [2:0]  field_idx;
    logic [15:0] wrap_len;
    logic [31:0] ber_len;
    logic [2:0]  ber_left;
    logic [63:0] title_sr;
    logic [3:0]  title_cnt;
    logic [15:0] ver, src, dst;
    logic [1:0]  sec;
    logic [31:0] fc;
    logic [dlms_ph_pkg::StatusW-1:0] first_err;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase = dlms_ph_pkg::PH_VER;
      byte_count = 0;
      field_idx = '0;
      wrap_len = '0;
      ber_len = '0;
      ber_left = '0;
      title_sr = '0;
      title_cnt = '0;
      ver = '0;
      src = '0;
      dst = '0;
      sec = dlms_ph_pkg::SEC_NONE;
      fc = '0;
      first_err = dlms_ph_pkg::ST_OK;
    endfunction

    function int pending();
      return expected_headers.size();
    endfunction

    function void record_err(logic [dlms_ph_pkg::StatusW-1:0] code);
      if (first_err == dlms_ph_pkg::ST_OK) first_err = code;
    endfunction

    // two-byte header words advance the phase after their second byte
    function void word_byte_done();
      field_idx++;
      if (field_idx >= 2) begin
        field_idx = '0;
        phase = phase + 1'b1;
      end
    endfunction

    function void begin_title(logic [31:0] len);
      if (len > MaxTitle) record_err(dlms_ph_pkg::ST_TITLE);
      ber_len = len;
      phase = (len == 0) ? dlms_ph_pkg::PH_CLEN : dlms_ph_pkg::PH_TITLE;
    endfunction

    function void length_complete();
      if (phase == dlms_ph_pkg::PH_TLEN || phase == dlms_ph_pkg::PH_TLEN_EXT)
        begin_title(ber_len);
      else phase = dlms_ph_pkg::PH_SEC;
    endfunction

    function void ber_lead(logic [7:0] b);
      logic [2:0] ext;
      if (b <= dlms_ph_pkg::BER_SHORT_MAX) begin
        ber_len = {24'd0, b};
        length_complete();
        return;
      end
      case (b)
        dlms_ph_pkg::BER_LONG1: ext = 3'd1;
        dlms_ph_pkg::BER_LONG2: ext = 3'd2;
        dlms_ph_pkg::BER_LONG4: ext = 3'd4;
        default: begin
          // with an earlier error kept, parsing is not stopped here
          record_err(dlms_ph_pkg::ST_BER);
          return;
        end
      endcase
      ber_len = '0;
      ber_left = ext;
      phase = phase + 1'b1;
    endfunction

    function void advance(logic [7:0] b);
      if (first_err == dlms_ph_pkg::ST_TAG || first_err == dlms_ph_pkg::ST_BER) return;
      if (phase >= dlms_ph_pkg::PH_SEC) begin
        if (ber_len == 0) record_err(dlms_ph_pkg::ST_CLEN);
        else ber_len--;
      end
      case (phase)
        dlms_ph_pkg::PH_VER: begin
          ver = {ver[7:0], b};
          word_byte_done();
        end
        dlms_ph_pkg::PH_SRC: begin
          src = {src[7:0], b};
          word_byte_done();
        end
        dlms_ph_pkg::PH_DST: begin
          dst = {dst[7:0], b};
          word_byte_done();
        end
        dlms_ph_pkg::PH_WLEN: begin
          wrap_len = {wrap_len[7:0], b};
          word_byte_done();
        end
        dlms_ph_pkg::PH_TAG: begin
          if (b == dlms_ph_pkg::TAG_GLO_CIPHER) phase = dlms_ph_pkg::PH_TLEN;
          else record_err(dlms_ph_pkg::ST_TAG);
        end
        dlms_ph_pkg::PH_TLEN, dlms_ph_pkg::PH_CLEN: ber_lead(b);
        dlms_ph_pkg::PH_TLEN_EXT, dlms_ph_pkg::PH_CLEN_EXT: begin
          ber_len = {ber_len[23:0], b};
          if (ber_left > 0) ber_left--;
          if (ber_left == 0) begin
            phase = phase - 1'b1;
            length_complete();
          end
        end
        dlms_ph_pkg::PH_TITLE: begin
          if (title_cnt < MaxTitle) begin
            title_sr = {title_sr[55:0], b};
            title_cnt++;
          end
          if (ber_len > 0) ber_len--;
          if (ber_len == 0) phase = dlms_ph_pkg::PH_CLEN;
        end
        dlms_ph_pkg::PH_SEC: begin
          case (b)
            dlms_ph_pkg::SC_AUTH:     sec = dlms_ph_pkg::SEC_AUTH;
            dlms_ph_pkg::SC_ENC:      sec = dlms_ph_pkg::SEC_ENC;
            dlms_ph_pkg::SC_AUTH_ENC: sec = dlms_ph_pkg::SEC_AUTH_ENC;
            default:                  sec = dlms_ph_pkg::SEC_NONE;
          endcase
          phase = dlms_ph_pkg::PH_FC;
        end
        dlms_ph_pkg::PH_FC: begin
          fc = {fc[23:0], b};
          field_idx++;
          if (field_idx >= 4) begin
            field_idx = '0;
            phase = dlms_ph_pkg::PH_PAYLOAD;
          end
        end
        default: ;
      endcase
    endfunction

    // called once per accepted request
    function void parse_byte(logic [7:0] b, logic is_last);
      push_result_t r;
      logic [dlms_ph_pkg::StatusW-1:0] st;
      if (byte_count < dlms_ph_pkg::COUNT_MAX) byte_count++;
      advance(b);
      if (!is_last) return;
      if (phase <= dlms_ph_pkg::PH_WLEN) st = dlms_ph_pkg::ST_TRUNC;
      else if (byte_count != wrap_len + 32'd8) st = dlms_ph_pkg::ST_WLEN;
      else if (first_err != dlms_ph_pkg::ST_OK) st = first_err;
      else if (phase >= dlms_ph_pkg::PH_SEC && ber_len != 0) st = dlms_ph_pkg::ST_CLEN;
      else if (phase < dlms_ph_pkg::PH_PAYLOAD) st = dlms_ph_pkg::ST_TRUNC;
      else st = dlms_ph_pkg::ST_OK;
      r.status        = st;
      r.version       = (phase > dlms_ph_pkg::PH_VER) ? ver : '0;
      r.source_addr   = (phase > dlms_ph_pkg::PH_SRC) ? src : '0;
      r.dest_addr     = (phase > dlms_ph_pkg::PH_DST) ? dst : '0;
      r.security_mode = (phase > dlms_ph_pkg::PH_SEC) ? sec : dlms_ph_pkg::SEC_NONE;
      r.frame_counter = (phase >= dlms_ph_pkg::PH_PAYLOAD) ? fc : '0;
      r.system_title  = (phase > dlms_ph_pkg::PH_TITLE) ? title_sr : '0;
      r.title_length  = (phase > dlms_ph_pkg::PH_TITLE) ? title_cnt : '0;
      expected_headers.insert(expected_headers.size(), r);
      clear_state();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_header(push_result_t got);
      push_result_t want;
      if (expected_headers.size() == 0) begin
        report("result with no packet pending");
        return;
      end
      want = expected_headers.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.version !== want.version)
        report($sformatf("version got %h want %h", got.version, want.version));
      if (got.source_addr !== want.source_addr)
        report($sformatf("source got %h want %h", got.source_addr, want.source_addr));
      if (got.dest_addr !== want.dest_addr)
        report($sformatf("dest got %h want %h", got.dest_addr, want.dest_addr));
      if (got.security_mode !== want.security_mode)
        report($sformatf("security got %0d want %0d", got.security_mode,
                         want.security_mode));
      if (got.frame_counter !== want.frame_counter)
        report($sformatf("frame counter got %h want %h", got.frame_counter,
                         want.frame_counter));
      if (got.system_title !== want.system_title)
        report($sformatf("title got %h want %h", got.system_title, want.system_title));
      if (got.title_length !== want.title_length)
        report($sformatf("title length got %0d want %0d", got.title_length,
                         want.title_length));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [15:0] out_version;
  logic [15:0] out_source_addr;
  logic [15:0] out_dest_addr;
  logic [1:0]  out_security_mode;
  logic [31:0] out_frame_counter;
  logic [63:0] out_system_title;
  logic [3:0]  out_title_length;

  push_header_scoreboard sb = new();
  logic [7:0] pkt_bytes[$];
  int  cycles = 0;
  int  bytes_sent = 0;
  int  quiet_left = 0;
  bit  no_gaps = 0;
  bit  hold_off_req = 0;

  dlms_push_header_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_version       (out_version),
    .out_source_addr   (out_source_addr),
    .out_dest_addr     (out_dest_addr),
    .out_security_mode (out_security_mode),
    .out_frame_counter (out_frame_counter),
    .out_system_title  (out_system_title),
    .out_title_length  (out_title_length)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_header({out_status, out_version, out_source_addr, out_dest_addr,
                       out_security_mode, out_frame_counter, out_system_title,
                       out_title_length});
  end

  // result side: random stall runs, quiet stretches, and one long hold-off on request
  initial begin : rx_side
    int run;
    int r;
    run = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 0;
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk);
        run = 0;
      end else if (run > 0) begin
        run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          out_stall <= 1'b0;
          run = $urandom_range(50, 200);
        end else if (r < 55) begin
          out_stall <= 1'b0;
          run = $urandom_range(0, 3);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          run = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(20, 60);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(40, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic void add_byte(logic [7:0] v);
    pkt_bytes.insert(pkt_bytes.size(), v);
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void put_word(logic [15:0] w);
    add_byte(w[15:8]);
    add_byte(w[7:0]);
  endfunction

  // short form when it fits (0x80 meaning 128), otherwise or at random a long form
  function automatic void put_ber(int unsigned n);
    int form;
    form = $urandom_range(0, 9);
    if (n <= 128 && form < 6) begin
      add_byte(n[7:0]);
    end else if (n <= 255 && form < 8) begin
      add_byte(dlms_ph_pkg::BER_LONG1);
      add_byte(n[7:0]);
    end else if (n <= 65535 && form < 9) begin
      add_byte(dlms_ph_pkg::BER_LONG2);
      put_word(n[15:0]);
    end else begin
      add_byte(dlms_ph_pkg::BER_LONG4);
      put_word(n[31:16]);
      put_word(n[15:0]);
    end
  endfunction

  function automatic logic [7:0] bad_ber_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(8'h83, 8'hFF)); while (v == dlms_ph_pkg::BER_LONG4);
    return v;
  endfunction

  function automatic void noise_packet(int len);
    pkt_bytes.delete();
    repeat (len) add_byte(8'($urandom));
  endfunction

  function automatic void build_packet(int tlen, int plen, int clen_delta, int wlen_delta,
                                       bit bad_tag, bit bad_ber, bit ber_in_cipher,
                                       int cut_len);
    int clen;
    int w;
    logic [7:0] b;
    pkt_bytes.delete();
    repeat (3) put_word(pick_word());
    put_word(16'h0000);
    if (bad_tag) begin
      do b = 8'($urandom); while (b == dlms_ph_pkg::TAG_GLO_CIPHER);
      add_byte(b);
    end else begin
      add_byte(dlms_ph_pkg::TAG_GLO_CIPHER);
    end
    if (bad_ber && !ber_in_cipher) add_byte(bad_ber_byte());
    else put_ber(tlen);
    repeat (tlen) add_byte(8'($urandom));
    clen = 5 + plen + clen_delta;
    if (clen < 0) clen = 0;
    if (bad_ber && ber_in_cipher) add_byte(bad_ber_byte());
    else put_ber(clen);
    case ($urandom_range(0, 4))
      0:       add_byte(dlms_ph_pkg::SC_AUTH);
      1:       add_byte(dlms_ph_pkg::SC_ENC);
      2:       add_byte(dlms_ph_pkg::SC_AUTH_ENC);
      default: add_byte(8'($urandom));
    endcase
    repeat (4 + plen) add_byte(8'($urandom));
    w = pkt_bytes.size() - 8 + wlen_delta;
    pkt_bytes[6] = w[15:8];
    pkt_bytes[7] = w[7:0];
    if (cut_len > 0)
      while (pkt_bytes.size() > cut_len) void'(pkt_bytes.pop_back());
  endfunction

  function automatic void random_packet();
    int tlen, plen, cdelta, wdelta, cut;
    bit btag, bber, bcip;
    if ($urandom_range(0, 99) < 5) begin
      noise_packet($urandom_range(1, 24));
      return;
    end
    tlen = $urandom_range(0, MaxTitle);
    if ($urandom_range(0, 99) < 12)
      tlen = ($urandom_range(0, 4) == 0) ? 128 : $urandom_range(MaxTitle + 1, 20);
    plen = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 12) : $urandom_range(13, 60);
    cdelta = 0;
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 1)) cdelta = -$urandom_range(1, plen + 5);
      else cdelta = $urandom_range(1, 300);
    end
    wdelta = 0;
    if ($urandom_range(0, 99) < 8)
      wdelta = $urandom_range(0, 1) ? $urandom_range(1, 5) : -$urandom_range(1, 5);
    btag = ($urandom_range(0, 99) < 6);
    bber = ($urandom_range(0, 99) < 7);
    bcip = $urandom_range(0, 1);
    cut = 0;
    if ($urandom_range(0, 99) < 10)
      cut = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(9, 40);
    build_packet(tlen, plen, cdelta, wdelta, btag, bber, bcip, cut);
  endfunction

  // valid stays high between back-to-back requests; lowered for a gap here and in wait_results
  task automatic send_byte(logic [7:0] b, logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last      <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.parse_byte(b, is_last);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    bytes_sent += pkt_bytes.size();
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_last = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // one-byte packet, then a bad tag right after the wrapper header
    pkt_bytes = '{8'hFF};
    send_packet();
    pkt_bytes = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00};
    send_packet();
    // smallest clean packet: empty title, cipher length 5
    pkt_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h08,
                  dlms_ph_pkg::TAG_GLO_CIPHER, 8'h00, 8'h05, dlms_ph_pkg::SC_AUTH_ENC,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_packet();

    for (int n = 0; bytes_sent < 1200 || n < 30; n++) begin
      if (n == 10) begin
        // result side holds off while short packets keep coming
        hold_off_req = 1;
        no_gaps = 1;
        repeat (8) begin
          noise_packet($urandom_range(1, 2));
          send_packet();
        end
        no_gaps = 0;
        wait_results();
      end
      if (n == 20) wait_results();
      random_packet();
      send_packet();
    end

    wait_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== dlms_push_header_parser.f =====
rtl/dlms_ph_pkg.sv
rtl/dlms_push_header_parser.sv
tb/tb_dlms_push_header_parser.sv
